>>> hdl/lbs_pkg.sv
// Package: shared constants, event codes and job type for the LED step sequencer.
`timescale 1ns / 1ps
package lbs_pkg;

	localparam int STEP_COUNT  = 6;
	localparam int PIXEL_COUNT = 12;

	localparam int SLOT_W    = 3;
	localparam int ACC_W     = 21;
	localparam int REG_W     = 20;
	localparam int ELAPSED_W = 16;
	localparam int PHASE_W   = 9;
	localparam int SCAN_W    = 5;
	localparam int POS_W     = 4;
	localparam int DUTY_W    = 9;
	localparam int PIXIDX_W  = 4;
	localparam int COLOR_W   = 8;
	localparam int PIX_W     = $clog2(PIXEL_COUNT);

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_TUSER_W = 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [REG_W-1:0] STEP_PERIOD_RST = 20'd5376;
	localparam logic [REG_W-1:0] PWM_PERIOD_RST  = 20'd42000;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 1'b1;

	localparam logic [PHASE_W-1:0] BREATHE_INC = 9'd5;
	localparam logic [PHASE_W-1:0] BREATHE_MID = 9'd255;
	localparam logic [DUTY_W-1:0]  DUTY_MIN    = 9'd3;
	localparam logic [DUTY_W-1:0]  DUTY_FULL   = 9'd255;
	localparam logic [DUTY_W-1:0]  DUTY_DIM    = 9'd5;
	localparam logic [SCAN_W-1:0]  SCAN_LAST   = 5'd23;
	localparam logic [SCAN_W-1:0]  SCAN_MID    = 5'd12;

	localparam logic [COLOR_W-1:0] AMBER_R = 8'd255;
	localparam logic [COLOR_W-1:0] AMBER_G = 8'd160;
	localparam logic [COLOR_W-1:0] DIM_R   = 8'd50;
	localparam logic [COLOR_W-1:0] DIM_G   = 8'd40;

	typedef enum logic [1:0] {
		EV_PWM   = 2'd0,
		EV_PIXEL = 2'd1,
		EV_SHOW  = 2'd2
	} event_kind_t;

	typedef struct packed {
		event_kind_t         kind;
		logic                light_on;
		logic [DUTY_W-1:0]   duty;
		logic [POS_W-1:0]    pos;
	} job_t;

endpackage

>>> hdl/lbs_tick.sv
// Tick front end: accumulator, step slot, phases, and the registered job.
`timescale 1ns / 1ps
module lbs_tick (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_valid,
	output logic                           tick_ready,
	input  logic [lbs_pkg::ELAPSED_W-1:0]  elapsed,
	input  logic                           light_on,
	input  logic [lbs_pkg::REG_W-1:0]      step_period,
	input  logic                           job_pop,
	output logic                           job_valid,
	output lbs_pkg::job_t                  job
);
	import lbs_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(STEP_COUNT - 1);
	localparam logic [SLOT_W-1:0] SLOT_PWM  = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_SCAN = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_SHOW = SLOT_W'(2);

	logic [ACC_W-1:0]   acc_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [PHASE_W-1:0] phase_q;
	logic [SCAN_W-1:0]  scan_q;
	logic               job_valid_s1;
	job_t               job_s1;

	logic [ACC_W-1:0]   acc_sum;
	logic               fire;
	logic               accept;
	logic [PHASE_W-1:0] phase_nxt;
	logic [DUTY_W-1:0]  phase_gap;
	logic [DUTY_W-1:0]  duty;
	logic [SCAN_W-1:0]  scan_nxt;
	logic [SCAN_W-1:0]  pos_full;
	logic               has_job;
	job_t               job_nxt;

	assign tick_ready = !job_valid_s1 || job_pop;
	assign accept     = tick_valid && tick_ready;

	always_comb begin
		acc_sum   = ACC_W'({1'b0, acc_q} + {{(ACC_W + 1 - ELAPSED_W){1'b0}}, elapsed});
		fire      = acc_sum > {{(ACC_W - REG_W){1'b0}}, step_period};
		phase_nxt = phase_q + BREATHE_INC;
		phase_gap = (phase_nxt >= BREATHE_MID) ? (phase_nxt - BREATHE_MID)
		                                       : (BREATHE_MID - phase_nxt);
		duty      = (phase_gap > DUTY_MIN) ? phase_gap : DUTY_MIN;
		scan_nxt  = (scan_q == SCAN_LAST) ? '0 : scan_q + SCAN_W'(1);
		pos_full  = (scan_nxt >= SCAN_MID) ? (scan_nxt - SCAN_MID) : (SCAN_MID - scan_nxt);
		job_nxt.light_on = light_on;
		job_nxt.duty     = duty;
		job_nxt.pos      = POS_W'(pos_full);
		job_nxt.kind     = EV_SHOW;
		has_job          = 1'b0;
		unique case (slot_q)
			SLOT_PWM: begin
				job_nxt.kind = EV_PWM;
				has_job      = fire;
			end
			SLOT_SCAN: begin
				job_nxt.kind = EV_PIXEL;
				has_job      = fire;
			end
			SLOT_SHOW: begin
				job_nxt.kind = EV_SHOW;
				has_job      = fire;
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			slot_q       <= '0;
			phase_q      <= '0;
			scan_q       <= '0;
			job_valid_s1 <= 1'b0;
		end else begin
			if (job_pop) begin
				job_valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (fire) begin
					acc_q  <= '0;
					slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
					if (slot_q == SLOT_PWM) begin
						phase_q <= phase_nxt;
					end
					if (slot_q == SLOT_SCAN) begin
						scan_q <= scan_nxt;
					end
				end else begin
					acc_q <= acc_sum;
				end
				if (has_job) begin
					job_valid_s1 <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_job) begin
			job_s1 <= job_nxt;
		end
	end

	assign job_valid = job_valid_s1;
	assign job       = job_s1;

endmodule

>>> hdl/lbs_emit.sv
// Result emitter: PWM compare scaling, pixel burst counter and output register.
`timescale 1ns / 1ps
module lbs_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	input  lbs_pkg::job_t                     job,
	output logic                              job_pop,
	input  logic [lbs_pkg::REG_W-1:0]         pwm_period,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lbs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic [lbs_pkg::OUT_TUSER_W-1:0]   m_tuser,
	output logic                              m_tlast
);
	import lbs_pkg::*;

	localparam int PROD_W = REG_W + DUTY_W;
	localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXEL_COUNT - 1);

	logic [PIX_W-1:0]    pix_q;
	logic                out_valid_q;
	event_kind_t         kind_q;
	logic [REG_W-1:0]    hc_q;
	logic [REG_W-1:0]    bc_q;
	logic [PIXIDX_W-1:0] idx_q;
	logic [COLOR_W-1:0]  red_q;
	logic [COLOR_W-1:0]  green_q;
	logic                last_q;

	logic                load;
	logic                job_end;
	logic [DUTY_W-1:0]   head_duty;
	logic [PROD_W-1:0]   hc_prod;
	logic [PROD_W-1:0]   bc_prod;
	logic [7:0]          pix8;
	logic [7:0]          pos8;
	logic [REG_W-1:0]    hc_nxt;
	logic [REG_W-1:0]    bc_nxt;
	logic [PIXIDX_W-1:0] idx_nxt;
	logic [COLOR_W-1:0]  red_nxt;
	logic [COLOR_W-1:0]  green_nxt;

	assign load    = !out_valid_q || m_tready;
	assign job_end = (job.kind != EV_PIXEL) || (pix_q == PIX_LAST);
	assign job_pop = load && job_valid && job_end;

	always_comb begin
		head_duty = job.light_on ? DUTY_FULL : DUTY_DIM;
		hc_prod   = {{DUTY_W{1'b0}}, pwm_period} * {{REG_W{1'b0}}, head_duty};
		bc_prod   = {{DUTY_W{1'b0}}, pwm_period} * {{REG_W{1'b0}}, job.duty};
		pix8      = 8'(pix_q);
		pos8      = 8'(job.pos);
		hc_nxt    = '0;
		bc_nxt    = '0;
		idx_nxt   = '0;
		red_nxt   = '0;
		green_nxt = '0;
		unique case (job.kind)
			EV_PWM: begin
				hc_nxt = hc_prod[REG_W+7:8];
				bc_nxt = bc_prod[REG_W+7:8];
			end
			EV_PIXEL: begin
				idx_nxt = PIXIDX_W'(pix_q);
				if (pix8 == pos8) begin
					red_nxt   = AMBER_R;
					green_nxt = AMBER_G;
				end else if ((pix8 + 8'd1 == pos8) || (pix8 == pos8 + 8'd1)) begin
					red_nxt   = DIM_R;
					green_nxt = DIM_G;
				end
			end
			EV_SHOW: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= job_valid;
			if (job_valid) begin
				pix_q <= job_end ? '0 : pix_q + PIX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && job_valid) begin
			kind_q  <= job.kind;
			hc_q    <= hc_nxt;
			bc_q    <= bc_nxt;
			idx_q   <= idx_nxt;
			red_q   <= red_nxt;
			green_q <= green_nxt;
			last_q  <= job_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {4'd0, {COLOR_W{1'b0}}, green_q, red_q, idx_q, bc_q, hc_q};

endmodule

>>> hdl/led_breathe_scan_sequencer.sv
// Top level: configuration registers, tick front end and result emitter.
//
// Each tick beat adds its elapsed time to an accumulator; once the sum exceeds
// step_period the next of six step slots runs. Slot 0 gives one PWM compare beat,
// slot 1 a burst of twelve pixel beats (one per cycle while tready is high, last
// one flagged by tlast), slot 2 one show beat, other slots nothing. A tick beat
// is taken every cycle while results flow; a pixel burst holds off the following
// tick until the emitter's pixel counter reaches the last pixel (longer while
// tready is low). Results pass the job, then the output register. The user must
// write registers only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module led_breathe_scan_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbs_pkg::REG_W-1:0]         cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// elapsed[15:0], light_on[16], zero pad
	input  logic [lbs_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// headlight_compare[19:0], breathe_compare[39:20], pixel_index[43:40],
	// red[51:44], green[59:52], blue[67:60], zero pad
	output logic [lbs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// event_kind[1:0]
	output logic [lbs_pkg::OUT_TUSER_W-1:0]   m_tuser,
	output logic                              m_tlast
);
	import lbs_pkg::*;

	logic [REG_W-1:0] step_period_q;
	logic [REG_W-1:0] pwm_period_q;
	logic             job_valid;
	logic             job_pop;
	job_t             job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= STEP_PERIOD_RST;
			pwm_period_q  <= PWM_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_PERIOD: step_period_q <= cfg_data;
				REG_PWM_PERIOD:  pwm_period_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lbs_tick u_tick (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (s_tvalid),
		.tick_ready  (s_tready),
		.elapsed     (s_tdata[ELAPSED_W-1:0]),
		.light_on    (s_tdata[ELAPSED_W]),
		.step_period (step_period_q),
		.job_pop     (job_pop),
		.job_valid   (job_valid),
		.job         (job)
	);

	lbs_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop),
		.pwm_period (pwm_period_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

>>> dv/led_sequence_checker.sv
// Checker: predicts the LED sequencer's result beats from tick beats and compares them.
`timescale 1ns / 1ps
module led_sequence_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbs_pkg::REG_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// elapsed[15:0], light_on[16], zero pad
	input  logic [lbs_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// headlight_compare[19:0], breathe_compare[39:20], pixel_index[43:40],
	// red[51:44], green[59:52], blue[67:60], zero pad
	input  logic [lbs_pkg::OUT_TDATA_W-1:0] m_tdata,
	// event_kind[1:0]
	input  logic [lbs_pkg::OUT_TUSER_W-1:0] m_tuser,
	input  logic                            m_tlast,
	output int                              mismatches,
	output int                              outstanding
);
	import lbs_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_PWM  = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_SCAN = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_SHOW = 3'd2;

	typedef struct packed {
		event_kind_t           kind;
		logic [REG_W-1:0]      headlight;
		logic [REG_W-1:0]      breathe;
		logic [PIXIDX_W-1:0]   pixel;
		logic [COLOR_W-1:0]    red;
		logic [COLOR_W-1:0]    green;
		logic [COLOR_W-1:0]    blue;
		logic                  last;
	} led_beat_t;

	led_beat_t expected_beats[$];
	led_beat_t head;
	int errs = 0;

	logic [REG_W-1:0]   step_period;
	logic [REG_W-1:0]   pwm_period;
	logic [ACC_W-1:0]   elapsed_sum;
	logic [SLOT_W-1:0]  slot;
	logic [PHASE_W-1:0] breathe_ph;
	logic [SCAN_W-1:0]  scan_ph;

	assign mismatches = errs;

	function automatic logic [REG_W-1:0] scale_by_duty(input logic [DUTY_W-1:0] duty);
		logic [63:0] prod;
		prod = {44'd0, pwm_period} * {55'd0, duty};
		return prod[REG_W+7:8];
	endfunction

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		errs++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
		end
	endtask

	task automatic predict_tick(input logic [ELAPSED_W-1:0] elapsed, input logic light);
		led_beat_t ev;
		logic [DUTY_W-1:0] phase_gap;
		logic [SCAN_W-1:0] pos;
		int i;
		elapsed_sum = elapsed_sum + elapsed;
		if (elapsed_sum > step_period) begin
			elapsed_sum = '0;
			ev = '0;
			ev.last = 1'b1;
			case (slot)
				SLOT_PWM: begin
					breathe_ph = breathe_ph + BREATHE_INC;
					phase_gap = (breathe_ph >= BREATHE_MID) ? breathe_ph - BREATHE_MID
						: BREATHE_MID - breathe_ph;
					ev.kind = EV_PWM;
					ev.headlight = scale_by_duty(light ? DUTY_FULL : DUTY_DIM);
					ev.breathe = scale_by_duty((phase_gap > DUTY_MIN) ? phase_gap : DUTY_MIN);
					expected_beats.push_back(ev);
				end
				SLOT_SCAN: begin
					scan_ph = (scan_ph == SCAN_LAST) ? '0 : scan_ph + 1'b1;
					pos = (scan_ph >= SCAN_MID) ? scan_ph - SCAN_MID : SCAN_MID - scan_ph;
					for (i = 0; i < PIXEL_COUNT; i++) begin
						ev = '0;
						ev.kind = EV_PIXEL;
						ev.pixel = i[PIXIDX_W-1:0];
						if (i == pos) begin
							ev.red = AMBER_R;
							ev.green = AMBER_G;
						end else if (i + 1 == pos || i == pos + 1) begin
							ev.red = DIM_R;
							ev.green = DIM_G;
						end
						ev.last = (i == PIXEL_COUNT - 1);
						expected_beats.push_back(ev);
					end
				end
				SLOT_SHOW: begin
					ev.kind = EV_SHOW;
					expected_beats.push_back(ev);
				end
				default: begin
				end
			endcase
			slot = (slot == STEP_COUNT - 1) ? '0 : slot + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period = STEP_PERIOD_RST;
			pwm_period = PWM_PERIOD_RST;
			elapsed_sum = '0;
			slot = '0;
			breathe_ph = '0;
			scan_ph = '0;
			expected_beats.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_beats.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					head = expected_beats.pop_front();
					check_field("event_kind", 32'(m_tuser), 32'(head.kind));
					check_field("headlight_compare", 32'(m_tdata[19:0]), 32'(head.headlight));
					check_field("breathe_compare", 32'(m_tdata[39:20]), 32'(head.breathe));
					check_field("pixel_index", 32'(m_tdata[43:40]), 32'(head.pixel));
					check_field("red", 32'(m_tdata[51:44]), 32'(head.red));
					check_field("green", 32'(m_tdata[59:52]), 32'(head.green));
					check_field("blue", 32'(m_tdata[67:60]), 32'(head.blue));
					check_field("last", 32'(m_tlast), 32'(head.last));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_tick(s_tdata[ELAPSED_W-1:0], s_tdata[ELAPSED_W]);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_PERIOD: step_period = cfg_data;
					REG_PWM_PERIOD: pwm_period = cfg_data;
					default: begin
					end
				endcase
			end
			outstanding <= expected_beats.size();
		end
	end

endmodule

>>> dv/tb.sv
// Testbench top: drives tick beats, register writes and result back-pressure; gives the verdict.
`timescale 1ns / 1ps
module tb;
	import lbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 300;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [REG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   m_tlast;

	int mismatches;
	int outstanding;
	int tx_idle_pct = 26;
	int rx_idle_pct = 62;
	logic hold_go = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	led_breathe_scan_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	led_sequence_checker seq_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
		if (hold_go || hold_left > 1) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed, input logic light);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, light, elapsed};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, wait for every expected beat, then let quiet ticks settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int count, input bit near_max);
		logic [ELAPSED_W-1:0] elapsed;
		repeat (count) begin
			if (near_max) begin
				elapsed = ELAPSED_W'($urandom_range(60000, 65535));
			end else begin
				case ($urandom_range(0, 9))
					0: elapsed = '0;
					1: elapsed = '1;
					default: elapsed = ELAPSED_W'($urandom_range(0, 65535));
				endcase
			end
			send_tick(elapsed, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_tick(16'd0, 1'b0);
		send_tick(16'd5376, 1'b1);      // sum equals threshold: no step
		send_tick(16'd1, 1'b1);         // PWM, headlight full
		send_tick(16'hFFFF, 1'b0);      // pixel burst
		send_tick(16'hFFFF, 1'b1);      // show
		repeat (3) send_tick(16'hFFFF, 1'b1);
		send_tick(16'hFFFF, 1'b0);      // PWM, headlight dim
		drain();

		write_reg(REG_STEP_PERIOD, '0);
		write_reg(REG_PWM_PERIOD, '0);
		send_tick(16'd0, 1'b1);
		repeat (6) send_tick(16'd1, 1'($urandom_range(0, 1)));
		drain();

		write_reg(REG_PWM_PERIOD, '1);
		run_random(100, 1'b0);
		drain();

		write_reg(REG_STEP_PERIOD, '1);
		write_reg(REG_PWM_PERIOD, 20'd1);
		run_random(30, 1'b1);
		drain();

		tx_idle_pct <= 62;
		rx_idle_pct <= 26;
		write_reg(REG_STEP_PERIOD, REG_W'($urandom_range(0, 4000)));
		write_reg(REG_PWM_PERIOD, REG_W'($urandom_range(1, 20'hFFFFF)));
		run_random(45, 1'b0);
		drain();
		run_random(45, 1'b0);
		drain();

		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		write_reg(REG_STEP_PERIOD, '0);
		write_reg(REG_PWM_PERIOD, REG_W'($urandom_range(1, 20'hFFFFF)));
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		run_random(60, 1'b0);
		drain();

		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
